[design/assert_macros.svh]
// Assertion macros used by the checker file.
// Plain text only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_AT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Same, on the default clk_i / rst_ni names.
`define ASSERT_DFLT(label, prop) `ASSERT_AT(label, clk_i, rst_ni, prop)

`endif

[design/i2c_rts_pkg.sv]
// Types and constants of the I2C register transfer sequencer.
// No dependencies; used by the top level and the checker.
package i2c_rts_pkg;

  localparam int MaxLen = 16;               // data buffer depth in bytes
  localparam int IdxW   = $clog2(MaxLen);   // buffer index width
  localparam logic [15:0] TimeoutRst = 16'd100;
  localparam logic ReadBit = 1'b1;

  typedef enum logic [2:0] {
    MODE_LOAD  = 3'd0,
    MODE_READ  = 3'd1,
    MODE_WRITE = 3'd2,
    MODE_STEP  = 3'd3,
    MODE_TICK  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_SEND  = 3'd2,
    CMD_RACK  = 3'd3,
    CMD_RNACK = 3'd4,
    CMD_STOP  = 3'd5,
    CMD_RESET = 3'd6
  } cmd_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_SADDR  = 4'd1,
    PH_SREG   = 4'd2,
    PH_WDATA  = 4'd3,
    PH_WSTOP  = 4'd4,
    PH_RSTART = 4'd5,
    PH_RADDR  = 4'd6,
    PH_RONE   = 4'd7,
    PH_RFIRST = 4'd8,
    PH_RMID   = 4'd9,
    PH_RLAST  = 4'd10,
    PH_RSTOP  = 4'd11
  } phase_e;

  // control sequencer: accept, execute, then read/deliver loop for read data
  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_EXEC,
    CTL_RD,
    CTL_DOUT
  } ctl_e;

  typedef struct packed {
    logic [2:0] mode;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [4:0] length;
    logic [3:0] byte_index;
    logic [7:0] byte_value;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    cmd_e       bus_cmd;
    logic [7:0] tx_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [3:0] data_index;
    logic       last;
    logic       busy_res;
  } res_t;

endpackage

[design/i2c_rts_intf.sv]
// Channel interfaces of the I2C register transfer sequencer: input items,
// result items and the configuration write. No dependencies.
interface i2c_rts_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [6:0] dev_addr;
  logic [7:0] reg_addr;
  logic [4:0] length;
  logic [3:0] byte_index;
  logic [7:0] byte_value;
  logic [7:0] rx_byte;

  modport source (output valid, mode, dev_addr, reg_addr, length, byte_index,
                  byte_value, rx_byte, input ready);
  modport sink   (input valid, mode, dev_addr, reg_addr, length, byte_index,
                  byte_value, rx_byte, output ready);
endinterface

interface i2c_rts_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] bus_cmd;
  logic [7:0] tx_byte;
  logic       data_valid;
  logic [7:0] data_byte;
  logic [3:0] data_index;
  logic       last;
  logic       busy_res;

  modport source (output valid, bus_cmd, tx_byte, data_valid, data_byte, data_index,
                  last, busy_res, input ready);
  modport sink   (input valid, bus_cmd, tx_byte, data_valid, data_byte, data_index,
                  last, busy_res, output ready);
endinterface

interface i2c_rts_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[design/i2c_register_transfer_sequencer.sv]
// Top level of the I2C register transfer sequencer.
// Depends on i2c_rts_pkg and the channel interfaces in i2c_rts_intf.sv.
//
// Register-addressed I2C master sequencer: each input item is a buffer load,
// a read or write start, a bus step done event or a timer tick, and yields the
// bus command for the next step. When the result register is free, the
// accept cycle issues the data buffer read and the next cycle uses the read
// data and registers the result. A read completion then delivers one STOP
// item plus one item per data byte, since the drain loop issues one
// registered buffer read per byte. A stalled result holds the sequencer.
// The user writes the timeout register through cfg_if only while the block
// is idle; the block itself does not enforce this.
module i2c_register_transfer_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  i2c_rts_in_if.sink       in_if,
  i2c_rts_out_if.source    out_if,
  i2c_rts_cfg_if.sink      cfg_if
);
  import i2c_rts_pkg::*;

  ctl_e   ctl_q, ctl_d;
  phase_e phase_q, phase_d;
  logic        is_write_q, is_write_d;
  logic [6:0]  tgt_addr_q, tgt_addr_d;
  logic [7:0]  tgt_reg_q, tgt_reg_d;
  logic [4:0]  xfer_len_q, xfer_len_d;
  logic [4:0]  byte_cnt_q, byte_cnt_d;
  logic [15:0] ticks_q, ticks_d;
  logic [15:0] timeout_q;
  logic [IdxW-1:0] dcnt_q;
  req_t req_q;

  logic       out_valid_q;
  res_t       res_q, res_d;

  // data buffer, one write and one registered read per cycle
  logic [7:0]      buf_mem [MaxLen];
  logic [7:0]      rdata_q;
  logic [IdxW-1:0] rd_addr;
  logic            buf_we;
  logic [IdxW-1:0] buf_waddr;
  logic [7:0]      buf_wdata;

  cmd_e        ex_cmd;
  logic [7:0]  ex_tx;
  logic        ex_drain;
  logic [4:0]  len_clamp;
  logic [15:0] ticks_inc;

  logic in_fire, slot_free, commit, dout_fire, load_out, dlast;

  // execute: model step on the latched item, applied only at commit
  always_comb begin
    ex_cmd     = CMD_NONE;
    ex_tx      = '0;
    ex_drain   = 1'b0;
    phase_d    = phase_q;
    is_write_d = is_write_q;
    tgt_addr_d = tgt_addr_q;
    tgt_reg_d  = tgt_reg_q;
    xfer_len_d = xfer_len_q;
    byte_cnt_d = byte_cnt_q;
    ticks_d    = ticks_q;
    buf_we     = 1'b0;
    buf_waddr  = byte_cnt_q[IdxW-1:0];
    buf_wdata  = req_q.rx_byte;
    ticks_inc  = (ticks_q == '1) ? ticks_q : ticks_q + 16'd1;
    if (req_q.length == 5'd0) begin
      len_clamp = 5'd1;
    end else if (req_q.length > 5'(MaxLen)) begin
      len_clamp = 5'(MaxLen);
    end else begin
      len_clamp = req_q.length;
    end

    case (req_q.mode)
      MODE_LOAD: begin
        if (phase_q == PH_IDLE) begin
          buf_we    = 1'b1;
          buf_waddr = req_q.byte_index[IdxW-1:0];
          buf_wdata = req_q.byte_value;
        end
      end
      MODE_READ, MODE_WRITE: begin
        if (phase_q == PH_IDLE) begin
          tgt_addr_d = req_q.dev_addr;
          tgt_reg_d  = req_q.reg_addr;
          xfer_len_d = len_clamp;
          byte_cnt_d = '0;
          is_write_d = (req_q.mode == MODE_WRITE);
          ticks_d    = '0;
          phase_d    = PH_SADDR;
          ex_cmd     = CMD_START;
        end
      end
      MODE_TICK: begin
        if (phase_q != PH_IDLE) begin
          ticks_d = ticks_inc;
          if (ticks_inc > timeout_q) begin
            phase_d = PH_IDLE;
            ex_cmd  = CMD_RESET;
          end
        end
      end
      MODE_STEP: begin
        unique case (phase_q)
          PH_SADDR: begin
            ex_cmd  = CMD_SEND;
            ex_tx   = {tgt_addr_q, 1'b0};
            phase_d = PH_SREG;
          end
          PH_SREG: begin
            ex_cmd  = CMD_SEND;
            ex_tx   = tgt_reg_q;
            phase_d = is_write_q ? PH_WDATA : PH_RSTART;
          end
          PH_WDATA: begin
            ex_cmd     = CMD_SEND;
            ex_tx      = rdata_q;
            byte_cnt_d = byte_cnt_q + 5'd1;
            if (byte_cnt_d >= xfer_len_q) phase_d = PH_WSTOP;
          end
          PH_WSTOP: begin
            ex_cmd  = CMD_STOP;
            phase_d = PH_IDLE;
          end
          PH_RSTART: begin
            ex_cmd  = CMD_START;
            phase_d = PH_RADDR;
          end
          PH_RADDR: begin
            ex_cmd  = CMD_SEND;
            ex_tx   = {tgt_addr_q, ReadBit};
            phase_d = (xfer_len_q == 5'd1) ? PH_RONE : PH_RFIRST;
          end
          PH_RONE: begin
            ex_cmd  = CMD_RNACK;
            phase_d = PH_RSTOP;
          end
          PH_RFIRST: begin
            ex_cmd  = CMD_RACK;
            phase_d = (xfer_len_q == 5'd2) ? PH_RLAST : PH_RMID;
          end
          PH_RMID: begin
            buf_we     = 1'b1;
            ex_cmd     = CMD_RACK;
            byte_cnt_d = byte_cnt_q + 5'd1;
            if ((6'(byte_cnt_d) + 6'd2) >= {1'b0, xfer_len_q}) phase_d = PH_RLAST;
          end
          PH_RLAST: begin
            buf_we     = 1'b1;
            ex_cmd     = CMD_RNACK;
            byte_cnt_d = byte_cnt_q + 5'd1;
            phase_d    = PH_RSTOP;
          end
          PH_RSTOP: begin
            buf_we   = 1'b1;
            ex_cmd   = CMD_STOP;
            phase_d  = PH_IDLE;
            ex_drain = 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // sequencer next state
  always_comb begin
    ctl_d = ctl_q;
    unique case (ctl_q)
      CTL_IDLE: if (in_fire) ctl_d = CTL_EXEC;
      CTL_EXEC: if (commit) ctl_d = ex_drain ? CTL_RD : CTL_IDLE;
      CTL_RD:   ctl_d = CTL_DOUT;
      CTL_DOUT: if (dout_fire) ctl_d = dlast ? CTL_IDLE : CTL_RD;
      default:  ctl_d = CTL_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_if.ready = (ctl_q == CTL_IDLE);
    in_fire     = in_if.valid && (ctl_q == CTL_IDLE);
    slot_free   = !out_valid_q || out_if.ready;
    commit      = (ctl_q == CTL_EXEC) && slot_free;
    dout_fire   = (ctl_q == CTL_DOUT) && slot_free;
    load_out    = commit || dout_fire;
    dlast       = (dcnt_q == IdxW'(xfer_len_q - 5'd1));
    // read port: drain counter while delivering, else the transfer byte slot
    rd_addr     = (ctl_q == CTL_RD || ctl_q == CTL_DOUT) ? dcnt_q
                                                         : byte_cnt_q[IdxW-1:0];
    res_d = '0;
    if (ctl_q == CTL_DOUT) begin
      res_d.bus_cmd    = CMD_NONE;
      res_d.data_valid = 1'b1;
      res_d.data_byte  = rdata_q;
      res_d.data_index = 4'(dcnt_q);
      res_d.last       = dlast;
    end else begin
      res_d.bus_cmd  = ex_cmd;
      res_d.tx_byte  = ex_tx;
      res_d.last     = !ex_drain;
      res_d.busy_res = (phase_d != PH_IDLE);
    end
  end

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= CTL_IDLE;
      phase_q     <= PH_IDLE;
      is_write_q  <= 1'b0;
      tgt_addr_q  <= '0;
      tgt_reg_q   <= '0;
      xfer_len_q  <= 5'd1;
      byte_cnt_q  <= '0;
      ticks_q     <= '0;
      timeout_q   <= TimeoutRst;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ctl_q <= ctl_d;
      if (cfg_if.valid) timeout_q <= cfg_if.data;
      if (commit) begin
        phase_q    <= phase_d;
        is_write_q <= is_write_d;
        tgt_addr_q <= tgt_addr_d;
        tgt_reg_q  <= tgt_reg_d;
        xfer_len_q <= xfer_len_d;
        byte_cnt_q <= byte_cnt_d;
        ticks_q    <= ticks_d;
      end
      if (commit && ex_drain) begin
        dcnt_q <= '0;
      end else if (dout_fire && !dlast) begin
        dcnt_q <= dcnt_q + IdxW'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q.mode       <= in_if.mode;
      req_q.dev_addr   <= in_if.dev_addr;
      req_q.reg_addr   <= in_if.reg_addr;
      req_q.length     <= in_if.length;
      req_q.byte_index <= in_if.byte_index;
      req_q.byte_value <= in_if.byte_value;
      req_q.rx_byte    <= in_if.rx_byte;
    end
    if (load_out) res_q <= res_d;
  end

  // Buffer writes land only at commit; the next read of that slot is issued
  // in a later cycle (drain starts in CTL_RD), so no bypass is needed.
  always_ff @(posedge clk_i) begin
    if (commit && buf_we) buf_mem[buf_waddr] <= buf_wdata;
    rdata_q <= buf_mem[rd_addr];
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.bus_cmd    = res_q.bus_cmd;
  assign out_if.tx_byte    = res_q.tx_byte;
  assign out_if.data_valid = res_q.data_valid;
  assign out_if.data_byte  = res_q.data_byte;
  assign out_if.data_index = res_q.data_index;
  assign out_if.last       = res_q.last;
  assign out_if.busy_res   = res_q.busy_res;

endmodule

[design/i2c_rts_checker.sv]
// Port-level checks for the I2C register transfer sequencer, bound to the
// top level. Depends on i2c_rts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2c_rts_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] out_bus_cmd_i,
  input logic [7:0] out_tx_byte_i,
  input logic       out_data_valid_i,
  input logic [7:0] out_data_byte_i,
  input logic [3:0] out_data_index_i,
  input logic       out_last_i,
  input logic       out_busy_i
);
  import i2c_rts_pkg::*;

  // a stalled result item holds
  `ASSERT_DFLT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_bus_cmd_i) && $stable(out_tx_byte_i) && $stable(out_data_byte_i) && $stable(out_data_index_i) && $stable(out_last_i))

  // one item at a time: no accept right after an accept
  `ASSERT_DFLT(a_in_gap, in_valid_i && in_ready_i |=> !in_ready_i)

  // while a multi-item result is still going out, no new item is taken
  `ASSERT_DFLT(a_burst_blocks, out_valid_i && !out_last_i |-> !in_ready_i)

  // read data items carry no bus command and follow the final STOP
  `ASSERT_DFLT(a_data_item, out_valid_i && out_data_valid_i |-> out_bus_cmd_i == CMD_NONE && out_tx_byte_i == 8'd0 && !out_busy_i)

  // a timeout abort ends the transfer
  `ASSERT_DFLT(a_abort_idle, out_valid_i && out_bus_cmd_i == CMD_RESET |-> !out_busy_i && out_last_i)

endmodule

bind i2c_register_transfer_sequencer i2c_rts_checker u_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_if.valid),
  .in_ready_i       (in_if.ready),
  .out_valid_i      (out_if.valid),
  .out_ready_i      (out_if.ready),
  .out_bus_cmd_i    (out_if.bus_cmd),
  .out_tx_byte_i    (out_if.tx_byte),
  .out_data_valid_i (out_if.data_valid),
  .out_data_byte_i  (out_if.data_byte),
  .out_data_index_i (out_if.data_index),
  .out_last_i       (out_if.last),
  .out_busy_i       (out_if.busy_res)
);
